FILE: src/ttdv_pkg.sv
// ----------------------------------------------------------------------------
// ttdv_pkg
// Shared widths, register indexes and control types of the two-tone tone
// generator with averaged volume.
// ----------------------------------------------------------------------------
package ttdv_pkg;

  localparam int STEP_W     = 26;
  localparam int ADC_W      = 12;
  localparam int DAC_W      = 12;
  localparam int ROM_W      = 16;
  localparam int VOL_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int OUTQ_DEPTH = 4;
  localparam int PROD_SHIFT = 17;

  localparam logic [63:0]      ROM_AMP   = 64'd32767;
  localparam logic [VOL_W-1:0] VOL_RESET = 12'd2048;
  localparam logic [DAC_W-1:0] DAC_MID   = 12'h800;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_B = 2'd1;

  // input word operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADC  = 1'b1;

  typedef struct packed {
    logic busy;
    logic clr_a;
    logic clr_b;
  } cfg_stat_t;

endpackage

FILE: src/ttdv_ram.sv
// ----------------------------------------------------------------------------
// ttdv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ttdv_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/ttdv_sine_rom.sv
// ----------------------------------------------------------------------------
// ttdv_sine_rom
// Dual-read sine table, 32767*sin(2*pi*i/N) truncated toward zero, with
// registered outputs. Contents are built at elaboration from a quarter wave.
// ----------------------------------------------------------------------------
module ttdv_sine_rom #(
  parameter int TABLE_SIZE = 1000
) (
  input  logic                                     clk,
  input  logic        [$clog2(TABLE_SIZE)-1:0]     addr_a,
  input  logic        [$clog2(TABLE_SIZE)-1:0]     addr_b,
  output logic signed [ttdv_pkg::ROM_W-1:0]        data_a,
  output logic signed [ttdv_pkg::ROM_W-1:0]        data_b
);

  localparam logic [63:0] PI_HALF = 64'h3243F6A8885A308D;

  // denominators (2k)(2k+1) of the taylor terms
  localparam logic [63:0] SERIES_DIV [1:13] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
  };

  // q61 fixed point product
  function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[124:61];
  endfunction

  function automatic logic [63:0] sine_mag(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q61(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 13; k++) begin
      term = mul_q61(term, x2) / SERIES_DIV[k];
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return mul_q61(sum, ttdv_pkg::ROM_AMP);
  endfunction

  logic signed [ttdv_pkg::ROM_W-1:0] rom_w [TABLE_SIZE];
  logic signed [ttdv_pkg::ROM_W-1:0] data_a_r;
  logic signed [ttdv_pkg::ROM_W-1:0] data_b_r;

  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_ent
    localparam longint unsigned A0 = 4 * longint'(gi);
    localparam bit NEG = A0 > 2 * longint'(TABLE_SIZE);
    localparam longint unsigned A1 = NEG ? 4 * longint'(TABLE_SIZE) - A0 : A0;
    localparam longint unsigned Q =
      (A1 > longint'(TABLE_SIZE)) ? 2 * longint'(TABLE_SIZE) - A1 : A1;
    localparam logic [63:0] X =
      (PI_HALF / TABLE_SIZE) * Q + ((PI_HALF % TABLE_SIZE) * Q) / TABLE_SIZE;
    localparam logic [63:0] MAG =
      (Q == 0) ? 64'd0 :
      (Q >= longint'(TABLE_SIZE)) ? ttdv_pkg::ROM_AMP : sine_mag(X);
    localparam logic [ttdv_pkg::ROM_W-1:0] VAL =
      NEG ? -ttdv_pkg::ROM_W'(MAG) : ttdv_pkg::ROM_W'(MAG);
    assign rom_w[gi] = VAL;
  end

  always_ff @(posedge clk) begin
    data_a_r <= rom_w[addr_a];
    data_b_r <= rom_w[addr_b];
  end

  assign data_a = data_a_r;
  assign data_b = data_b_r;

endmodule

FILE: src/ttdv_step_red.sv
// ----------------------------------------------------------------------------
// ttdv_step_red
// Step register file. A written step is reduced modulo the phase range by
// shift-and-subtract, one bit per cycle, so the phase adder needs only a
// single wrap.
// ----------------------------------------------------------------------------
module ttdv_step_red #(
  parameter int TABLE_SIZE = 1000,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             cfg_valid,
  output logic                                             cfg_ready,
  input  logic [ttdv_pkg::CFG_IDX_W-1:0]                   cfg_index,
  input  logic [ttdv_pkg::STEP_W-1:0]                      cfg_data,
  output logic [$clog2(TABLE_SIZE)+FRAC_BITS-1:0]          step_a,
  output logic [$clog2(TABLE_SIZE)+FRAC_BITS-1:0]          step_b,
  output ttdv_pkg::cfg_stat_t                              stat
);

  localparam int PH_W = $clog2(TABLE_SIZE) + FRAC_BITS;
  localparam int STEP_W = ttdv_pkg::STEP_W;
  localparam longint unsigned LIM = longint'(TABLE_SIZE) << FRAC_BITS;
  localparam int LIM_W = $clog2(LIM + 1);
  localparam int RED_STEPS = (STEP_W >= LIM_W) ? STEP_W - LIM_W + 1 : 1;
  localparam int DIV_W = LIM_W + RED_STEPS - 1;
  localparam int CNT_W = $clog2(RED_STEPS + 1);
  localparam logic [DIV_W-1:0] DIV_INIT = DIV_W'(LIM << (RED_STEPS - 1));

  logic                 busy_r;
  logic                 sel_b_r;
  logic [STEP_W-1:0]    rem_r;
  logic [DIV_W-1:0]     div_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [PH_W-1:0]      step_a_r;
  logic [PH_W-1:0]      step_b_r;
  logic [STEP_W-1:0]    rem_nxt;
  logic                 wr_acc;
  logic                 hit_a;
  logic                 hit_b;

  assign cfg_ready = !busy_r;
  assign wr_acc    = cfg_valid && cfg_ready;
  assign hit_a     = wr_acc && (cfg_index == ttdv_pkg::REG_STEP_A);
  assign hit_b     = wr_acc && (cfg_index == ttdv_pkg::REG_STEP_B);

  always_comb begin
    rem_nxt = rem_r;
    if (DIV_W'(rem_r) >= div_r) begin
      rem_nxt = rem_r - STEP_W'(div_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      sel_b_r  <= 1'b0;
      cnt_r    <= '0;
      step_a_r <= '0;
      step_b_r <= '0;
    end else if (hit_a || hit_b) begin
      busy_r  <= 1'b1;
      sel_b_r <= hit_b;
      cnt_r   <= CNT_W'(RED_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        if (sel_b_r) begin
          step_b_r <= PH_W'(rem_nxt);
        end else begin
          step_a_r <= PH_W'(rem_nxt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit_a || hit_b) begin
      rem_r <= cfg_data;
      div_r <= DIV_INIT;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      div_r <= div_r >> 1;
    end
  end

  assign step_a     = step_a_r;
  assign step_b     = step_b_r;
  assign stat.busy  = busy_r;
  assign stat.clr_a = hit_a && (cfg_data == '0);
  assign stat.clr_b = hit_b && (cfg_data == '0);

endmodule

FILE: src/ttdv_out_q.sv
// ----------------------------------------------------------------------------
// ttdv_out_q
// Result queue with credit count. A slot is reserved when a tick enters the
// pipeline, so the pipeline itself never has to stall.
// ----------------------------------------------------------------------------
module ttdv_out_q (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          reserve,
  input  logic                          push,
  input  logic [ttdv_pkg::DAC_W-1:0]    push_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ttdv_pkg::DAC_W-1:0]    out_data,
  output logic                          full
);

  localparam int DEPTH = ttdv_pkg::OUTQ_DEPTH;
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [ttdv_pkg::DAC_W-1:0] slot_r [DEPTH];
  logic [PW-1:0]              wr_ptr_r;
  logic [PW-1:0]              rd_ptr_r;
  logic [CW-1:0]              occ_r;
  logic [CW-1:0]              credit_r;
  logic                       pop;

  assign out_valid = (occ_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = slot_r[rd_ptr_r];
  assign full      = (credit_r == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
      credit_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      occ_r    <= occ_r + CW'(push) - CW'(pop);
      credit_r <= credit_r + CW'(reserve) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/two_tone_dds_with_volume_average.sv
// ----------------------------------------------------------------------------
// two_tone_dds_with_volume_average
// Two-channel sine synthesizer: phase accumulators feed a dual-read sine ROM,
// the summed samples are scaled by a volume averaged over a boxcar held in a RAM.
// ----------------------------------------------------------------------------
// a sample tick's dac code is registered at the rom outputs and the sum, then
// written into the result queue; one word per cycle while no step write is
// being reduced, bounded by the 4-entry result queue credits; a step write
// holds ready low for its modulo reduction
// reset (synchronous, rst_n low): phases, steps, ring valid bits, sum and
// position clear, volume returns to 2048, result queue empties
// ----------------------------------------------------------------------------
module two_tone_dds_with_volume_average #(
  parameter int TABLE_SIZE = 1000,
  parameter int AVG_DEPTH  = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [ttdv_pkg::ADC_W-1:0]          in_adc_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ttdv_pkg::DAC_W-1:0]          out_dac_code,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ttdv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttdv_pkg::STEP_W-1:0]         cfg_data
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int PH_W = AW + FRAC_BITS;
  localparam longint unsigned LIM = longint'(TABLE_SIZE) << FRAC_BITS;
  localparam logic [PH_W:0] LIM_X = (PH_W + 1)'(LIM);
  localparam int ADC_W = ttdv_pkg::ADC_W;
  localparam int VOL_W = ttdv_pkg::VOL_W;
  localparam int ROM_W = ttdv_pkg::ROM_W;
  localparam int RW = $clog2(AVG_DEPTH);
  localparam int SUM_W = ADC_W + RW;
  localparam int DIV_SH = SUM_W + RW;
  localparam int RCP_W = SUM_W + 2;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << DIV_SH) + AVG_DEPTH - 1) / AVG_DEPTH);
  localparam int PROD_W = ROM_W + 1 + VOL_W + 1;

  ttdv_pkg::cfg_stat_t cfg_stat;

  logic [PH_W-1:0]  step_a;
  logic [PH_W-1:0]  step_b;
  logic [PH_W-1:0]  phase_a_r;
  logic [PH_W-1:0]  phase_b_r;
  logic [PH_W:0]    sum_a;
  logic [PH_W:0]    sum_b;
  logic [PH_W-1:0]  phase_a_nxt;
  logic [PH_W-1:0]  phase_b_nxt;

  logic             in_acc;
  logic             tick_acc;
  logic             vol_acc;
  logic             q_full;

  logic signed [ROM_W-1:0]  rom_a;
  logic signed [ROM_W-1:0]  rom_b;
  logic                     t1_vld_r;
  logic                     t2_vld_r;
  logic signed [ROM_W:0]    tsum_r;
  logic signed [PROD_W-1:0] prod;
  logic [ttdv_pkg::DAC_W-1:0] code;

  logic [RW-1:0]            pos_r;
  logic [RW-1:0]            pos1_r;
  logic [ADC_W-1:0]         smp1_r;
  logic                     v1_vld_r;
  logic                     v2_vld_r;
  logic [AVG_DEPTH-1:0]     ring_vld_r;
  logic [ADC_W-1:0]         ring_rd;
  logic [ADC_W-1:0]         old_smp;
  logic [SUM_W-1:0]         avg_sum_r;
  logic [SUM_W-1:0]         avg_sum_nxt;
  logic [SUM_W+RCP_W-1:0]   vol_prod;
  logic [VOL_W-1:0]         volume_r;

  assign in_ready = !cfg_stat.busy && !q_full;
  assign in_acc   = in_valid && in_ready;
  assign tick_acc = in_acc && (in_op == ttdv_pkg::OP_TICK);
  assign vol_acc  = in_acc && (in_op == ttdv_pkg::OP_ADC);

  ttdv_step_red #(
    .TABLE_SIZE (TABLE_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step_a    (step_a),
    .step_b    (step_b),
    .stat      (cfg_stat)
  );

  // steps are already below the phase range, so one wrap is enough
  always_comb begin
    sum_a = {1'b0, phase_a_r} + {1'b0, step_a};
    sum_b = {1'b0, phase_b_r} + {1'b0, step_b};
    if (sum_a >= LIM_X) begin
      sum_a = sum_a - LIM_X;
    end
    if (sum_b >= LIM_X) begin
      sum_b = sum_b - LIM_X;
    end
    phase_a_nxt = sum_a[PH_W-1:0];
    phase_b_nxt = sum_b[PH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_a_r <= '0;
      phase_b_r <= '0;
    end else begin
      if (cfg_stat.clr_a) begin
        phase_a_r <= '0;
      end else if (tick_acc) begin
        phase_a_r <= phase_a_nxt;
      end
      if (cfg_stat.clr_b) begin
        phase_b_r <= '0;
      end else if (tick_acc) begin
        phase_b_r <= phase_b_nxt;
      end
    end
  end

  ttdv_sine_rom #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_rom (
    .clk    (clk),
    .addr_a (phase_a_nxt[PH_W-1:FRAC_BITS]),
    .addr_b (phase_b_nxt[PH_W-1:FRAC_BITS]),
    .data_a (rom_a),
    .data_b (rom_b)
  );

  // tick pipeline: rom read, sum, scale into the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
    end else begin
      t1_vld_r <= tick_acc;
      t2_vld_r <= t1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    tsum_r <= (ROM_W + 1)'(rom_a) + (ROM_W + 1)'(rom_b);
  end

  // volume is read beside the registered sum, behind the rom and sum registers,
  // which orders it against averaging words accepted before and after this tick
  assign prod = PROD_W'(tsum_r) * $signed({1'b0, volume_r});
  // floor shift plus mid-scale offset is a flip of the top code bit
  assign code = prod[ttdv_pkg::PROD_SHIFT +: ttdv_pkg::DAC_W] ^ ttdv_pkg::DAC_MID;

  ttdv_out_q u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .reserve   (tick_acc),
    .push      (t2_vld_r),
    .push_data (code),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_dac_code),
    .full      (q_full)
  );

  // boxcar: read the oldest entry, then replace it the next cycle; the
  // position has moved on by then, so read and write never meet
  ttdv_ram #(
    .WIDTH (ADC_W),
    .DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (v1_vld_r),
    .waddr (pos1_r),
    .wdata (smp1_r),
    .raddr (pos_r),
    .rdata (ring_rd)
  );

  assign old_smp     = ring_vld_r[pos1_r] ? ring_rd : '0;
  assign avg_sum_nxt = avg_sum_r - SUM_W'(old_smp) + SUM_W'(smp1_r);
  assign vol_prod    = (SUM_W + RCP_W)'(avg_sum_r) * (SUM_W + RCP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      v1_vld_r   <= 1'b0;
      v2_vld_r   <= 1'b0;
      ring_vld_r <= '0;
      avg_sum_r  <= '0;
      volume_r   <= ttdv_pkg::VOL_RESET;
    end else begin
      v1_vld_r <= vol_acc;
      v2_vld_r <= v1_vld_r;
      if (vol_acc) begin
        pos_r <= (pos_r == RW'(AVG_DEPTH - 1)) ? '0 : pos_r + 1'b1;
      end
      if (v1_vld_r) begin
        ring_vld_r[pos1_r] <= 1'b1;
        avg_sum_r          <= avg_sum_nxt;
      end
      if (v2_vld_r) begin
        volume_r <= vol_prod[DIV_SH +: VOL_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vol_acc) begin
      pos1_r <= pos_r;
      smp1_r <= in_adc_sample;
    end
  end

endmodule

FILE: src/ttdv_checker.sv
// ----------------------------------------------------------------------------
// ttdv_checker
// Port-level checks of the tone generator, bound to the top level.
// ----------------------------------------------------------------------------
module ttdv_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_op,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [ttdv_pkg::DAC_W-1:0]          out_dac_code,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [ttdv_pkg::CFG_IDX_W-1:0]      cfg_index
);

  // nothing is offered straight out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dac_code))
    else $error("stalled result changed");

  // a result only appears after an accepted sample tick
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_op == ttdv_pkg::OP_TICK), 3))
    else $error("result without a sample tick");

  // a step write blocks items and further config writes while the step is reduced
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready &&
    (cfg_index == ttdv_pkg::REG_STEP_A || cfg_index == ttdv_pkg::REG_STEP_B)
    |=> !in_ready && !cfg_ready)
    else $error("items taken during step update");

endmodule

bind two_tone_dds_with_volume_average ttdv_checker u_ttdv_checker (.*);

FILE: tb/sv/tb_two_tone_dds_with_volume_average.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_tone_dds_with_volume_average
// Drives sample ticks and volume samples through valid/ready with random
// gaps and stalls, rewrites both step registers between phases, and checks
// every dac code against a fixed code or an in-bench model of the phase
// accumulators, the sine table and the boxcar volume average.
// ----------------------------------------------------------------------------
module tb_two_tone_dds_with_volume_average;

  localparam int ADC_W      = ttdv_pkg::ADC_W;
  localparam int DAC_W      = ttdv_pkg::DAC_W;
  localparam int ROM_W      = ttdv_pkg::ROM_W;
  localparam int VOL_W      = ttdv_pkg::VOL_W;
  localparam int STEP_W     = ttdv_pkg::STEP_W;
  localparam int CFG_IDX_W  = ttdv_pkg::CFG_IDX_W;
  localparam int PROD_SHIFT = ttdv_pkg::PROD_SHIFT;
  localparam logic [63:0]      ROM_AMP   = ttdv_pkg::ROM_AMP;
  localparam logic [DAC_W-1:0] DAC_MID   = ttdv_pkg::DAC_MID;
  localparam logic [VOL_W-1:0] VOL_RESET = ttdv_pkg::VOL_RESET;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_A = ttdv_pkg::REG_STEP_A;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_B = ttdv_pkg::REG_STEP_B;
  localparam logic OP_TICK = ttdv_pkg::OP_TICK;
  localparam logic OP_ADC  = ttdv_pkg::OP_ADC;

  localparam int TABLE_N = 1000;
  localparam int AVG_N   = 32;
  localparam int FRAC_N  = 16;
  localparam bit [63:0] PHASE_WRAP = TABLE_N * (64'd1 << FRAC_N);
  localparam bit [63:0] PIHALF_Q61 = 64'h3243F6A8885A308D;
  localparam int IDLE_PAD = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;
  typedef struct packed {
    row_kind_t            kind;
    logic                 op;
    logic [ADC_W-1:0]     adc;
    logic [CFG_IDX_W-1:0] idx;
    logic [STEP_W-1:0]    data;
    logic                 fixed;
    logic [DAC_W-1:0]     dac;
  } row_t;

  localparam int DIR_N = 27;
  row_t dir_rows [DIR_N] = '{
    '{ROW_WORD, OP_TICK, 12'd0,    2'd0,        26'd0,        1'b1, 12'd2048},
    '{ROW_REG,  OP_TICK, 12'd0,    REG_SPARE_2, 26'h3FFFFFF,  1'b0, 12'd0},
    '{ROW_REG,  OP_TICK, 12'd0,    REG_SPARE_3, 26'd12345,    1'b0, 12'd0},
    '{ROW_WORD, OP_TICK, 12'd0,    2'd0,        26'd0,        1'b1, 12'd2048},
    '{ROW_REG,  OP_TICK, 12'd0,    REG_STEP_A,  26'd16384000, 1'b0, 12'd0},
    '{ROW_WORD, OP_TICK, 12'd0,    2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_WORD, OP_ADC,  12'd4095, 2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_WORD, OP_TICK, 12'd0,    2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_REG,  OP_TICK, 12'd0,    REG_STEP_B,  26'h3FFFFFF,  1'b0, 12'd0},
    '{ROW_WORD, OP_TICK, 12'd0,    2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_WORD, OP_TICK, 12'd0,    2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_REG,  OP_TICK, 12'd0,    REG_STEP_A,  26'd65535999, 1'b0, 12'd0},
    '{ROW_WORD, OP_TICK, 12'd0,    2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_WORD, OP_ADC,  12'd0,    2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_WORD, OP_ADC,  12'hAAA,  2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_WORD, OP_ADC,  12'h555,  2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_WORD, OP_TICK, 12'd0,    2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_REG,  OP_TICK, 12'd0,    REG_STEP_A,  26'd65536,    1'b0, 12'd0},
    '{ROW_WORD, OP_TICK, 12'd0,    2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_REG,  OP_TICK, 12'd0,    REG_STEP_A,  26'd0,        1'b0, 12'd0},
    '{ROW_REG,  OP_TICK, 12'd0,    REG_STEP_B,  26'd0,        1'b0, 12'd0},
    '{ROW_WORD, OP_TICK, 12'd0,    2'd0,        26'd0,        1'b1, 12'd2048},
    '{ROW_REG,  OP_TICK, 12'd0,    REG_STEP_A,  26'd49152000, 1'b0, 12'd0},
    '{ROW_REG,  OP_TICK, 12'd0,    REG_STEP_B,  26'd49152000, 1'b0, 12'd0},
    '{ROW_WORD, OP_TICK, 12'd0,    2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_WORD, OP_ADC,  12'd4095, 2'd0,        26'd0,        1'b0, 12'd0},
    '{ROW_WORD, OP_TICK, 12'd0,    2'd0,        26'd0,        1'b0, 12'd0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_op;
  logic [ADC_W-1:0]     in_adc_sample;
  logic                 out_valid;
  logic                 out_ready;
  logic [DAC_W-1:0]     out_dac_code;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STEP_W-1:0]    cfg_data;

  // model state
  logic signed [ROM_W-1:0] sine_tab [TABLE_N];
  logic [STEP_W-1:0]       tone_step_a, tone_step_b;
  logic [STEP_W-1:0]       tone_phase_a, tone_phase_b;
  logic [ADC_W-1:0]        vol_ring [AVG_N];
  logic [16:0]             vol_sum;
  int                      vol_pos;
  logic [VOL_W-1:0]        vol_level;

  logic [DAC_W-1:0] dac_expected [$];
  logic [DAC_W-1:0] dac_head;
  int               mismatches;
  bit               steady;

  two_tone_dds_with_volume_average #(
    .TABLE_SIZE(TABLE_N),
    .AVG_DEPTH (AVG_N),
    .FRAC_BITS (FRAC_N)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_adc_sample(in_adc_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_dac_code (out_dac_code),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb_two_tone_dds_with_volume_average failed");
    $finish;
  end

  // bits 124:61 of the full product
  function automatic bit [63:0] mul_q61(bit [63:0] a, bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[124:61];
  endfunction

  // truncated sine table, built with the same fixed-point series as the rom
  initial begin : build_sine
    bit [63:0] n, a, x, x2, term, acc, mag, den;
    bit        neg;
    n = TABLE_N;
    for (int i = 0; i < TABLE_N; i++) begin
      a   = 4 * i;
      neg = 1'b0;
      if (a > 2 * n) begin
        a   = 4 * n - a;
        neg = 1'b1;
      end
      if (a > n) a = 2 * n - a;
      if (a == 0) begin
        mag = 0;
      end else if (a >= n) begin
        mag = ROM_AMP;
      end else begin
        x    = (PIHALF_Q61 / n) * a + ((PIHALF_Q61 % n) * a) / n;
        x2   = mul_q61(x, x);
        term = x;
        acc  = x;
        for (int k = 1; k <= 13; k++) begin
          den  = (2 * k) * (2 * k + 1);
          term = mul_q61(term, x2) / den;
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
        mag = mul_q61(acc, ROM_AMP);
      end
      sine_tab[i] = neg ? -mag[15:0] : mag[15:0];
    end
  end

  function automatic logic [STEP_W-1:0] advance_phase(logic [STEP_W-1:0] ph,
                                                      logic [STEP_W-1:0] st);
    bit [63:0] p;
    p = {38'd0, ph} + {38'd0, st};
    if (p >= PHASE_WRAP) p = p - PHASE_WRAP;
    if (p >= PHASE_WRAP) p = p % PHASE_WRAP;
    return p[STEP_W-1:0];
  endfunction

  // one accepted word through the model; returns 1 when a dac code results
  function automatic bit tone_predict(logic op, logic [ADC_W-1:0] adc,
                                      output logic [DAC_W-1:0] dac);
    int     ia, ib;
    longint prod, scaled;
    dac = '0;
    if (op == OP_ADC) begin
      vol_sum           = vol_sum - vol_ring[vol_pos] + adc;
      vol_ring[vol_pos] = adc;
      vol_pos           = (vol_pos + 1) % AVG_N;
      vol_level         = VOL_W'(vol_sum / AVG_N);
      return 1'b0;
    end
    tone_phase_a = advance_phase(tone_phase_a, tone_step_a);
    tone_phase_b = advance_phase(tone_phase_b, tone_step_b);
    ia     = int'(tone_phase_a >> FRAC_N);
    ib     = int'(tone_phase_b >> FRAC_N);
    prod   = longint'(int'(sine_tab[ia]) + int'(sine_tab[ib])) * longint'(vol_level);
    // arithmetic shift floors toward minus infinity
    scaled = (prod >>> PROD_SHIFT) + longint'(DAC_MID);
    dac    = scaled[DAC_W-1:0];
    return 1'b1;
  endfunction

  function automatic bit take_gap();
    return !steady && ($urandom_range(99, 0) < 35);
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      2: return STEP_W'(PHASE_WRAP - 1);
      3: return STEP_W'($urandom_range(67108863, 65536000));
      4: return STEP_W'($urandom_range(65535, 1));
      default: return STEP_W'($urandom_range(65535999, 1));
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [DAC_W-1:0] got,
                                 logic [DAC_W-1:0] want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // result side: check against the oldest expected code, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (dac_expected.size() == 0) begin
        report_mismatch("dac code with nothing expected", out_dac_code, '0);
      end else begin
        dac_head = dac_expected.pop_front();
        if (out_dac_code !== dac_head) report_mismatch("dac_code", out_dac_code, dac_head);
      end
    end
    out_ready <= !take_gap();
  end

  task automatic send_word(logic op, logic [ADC_W-1:0] adc, logic fixed,
                           logic [DAC_W-1:0] fixed_dac);
    logic [DAC_W-1:0] dac;
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_adc_sample <= adc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tone_predict(op, adc, dac)) dac_expected.push_back(fixed ? fixed_dac : dac);
  endtask

  // volume words leave no trace in the queue, so pad past the pipeline too
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (dac_expected.size() != 0);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_STEP_A) begin
      tone_step_a = val;
      if (val == 0) tone_phase_a = '0;
    end else if (idx == REG_STEP_B) begin
      tone_step_b = val;
      if (val == 0) tone_phase_b = '0;
    end
  endtask

  initial begin : stimulus
    int               phase_words;
    int               r;
    logic [ADC_W-1:0] level;
    in_valid      = 1'b0;
    in_op         = OP_TICK;
    in_adc_sample = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    out_ready     = 1'b0;
    rst_n         = 1'b0;
    steady        = 1'b0;
    mismatches    = 0;
    tone_step_a   = '0;
    tone_step_b   = '0;
    tone_phase_a  = '0;
    tone_phase_b  = '0;
    vol_sum       = '0;
    vol_pos       = 0;
    vol_level     = VOL_RESET;
    for (int i = 0; i < AVG_N; i++) vol_ring[i] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].kind == ROW_REG) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_word(dir_rows[i].op, dir_rows[i].adc, dir_rows[i].fixed, dir_rows[i].dac);
    end

    for (int ph = 0; ph < 18; ph++) begin
      // two phases run with no gaps or stalls at all
      steady = (ph == 6 || ph == 7);
      write_reg(REG_STEP_A, pick_step());
      write_reg(REG_STEP_B, pick_step());
      if ($urandom_range(3, 0) == 0)
        write_reg($urandom_range(1, 0) ? REG_SPARE_2 : REG_SPARE_3, STEP_W'($urandom()));
      phase_words = 0;
      while (phase_words < 100) begin
        r = $urandom_range(99, 0);
        if (r < 1) begin
          // refill the whole average window, often with an extreme level
          case ($urandom_range(2, 0))
            0: level = '0;
            1: level = '1;
            default: level = ADC_W'($urandom());
          endcase
          repeat (AVG_N) send_word(OP_ADC, level, 1'b0, '0);
          phase_words += AVG_N;
        end else if (r < 30) begin
          send_word(OP_ADC, ADC_W'($urandom()), 1'b0, '0);
          phase_words++;
        end else begin
          send_word(OP_TICK, ADC_W'($urandom()), 1'b0, '0);
          phase_words++;
        end
      end
    end
    steady = 1'b0;
    wait_idle();

    if (mismatches == 0) begin
      $display("tb_two_tone_dds_with_volume_average passed");
    end else begin
      $display("tb_two_tone_dds_with_volume_average failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ttdv_pkg.sv
src/ttdv_ram.sv
src/ttdv_sine_rom.sv
src/ttdv_step_red.sv
src/ttdv_out_q.sv
src/two_tone_dds_with_volume_average.sv
src/ttdv_checker.sv
tb/sv/tb_two_tone_dds_with_volume_average.sv
